// ----- hw/rtl/utd_pkg.sv -----
package utd_pkg;

    // replacement character for malformed input
    localparam logic [20:0] ReplChar = 21'h00FFFD;

    // parse state, one-hot
    typedef enum logic [12:0] {
        ST_START   = 13'b0_0000_0000_0001,
        ST_ERR1    = 13'b0_0000_0000_0010,
        ST_ERR2    = 13'b0_0000_0000_0100,
        ST_ERR3    = 13'b0_0000_0000_1000,
        ST_ERR4    = 13'b0_0000_0001_0000,
        ST_ERR5    = 13'b0_0000_0010_0000,
        ST_NEED1   = 13'b0_0000_0100_0000,
        ST_NEED2   = 13'b0_0000_1000_0000,
        ST_NEED3   = 13'b0_0001_0000_0000,
        ST_LEAD_E0 = 13'b0_0010_0000_0000,
        ST_LEAD_ED = 13'b0_0100_0000_0000,
        ST_LEAD_F0 = 13'b0_1000_0000_0000,
        ST_LEAD_F4 = 13'b1_0000_0000_0000
    } parse_state_t;

    // one queued result word
    typedef struct packed {
        logic [20:0] code_point;
        logic        is_replacement;
        logic        last_of_run;
    } result_t;

    // outcome of decoding one byte from the start state
    typedef struct packed {
        logic         emit;
        logic [20:0]  code_point;
        logic         is_replacement;
        parse_state_t state;
        logic [14:0]  partial;
    } decode_t;

endpackage

// ----- hw/rtl/utd_stream_if.sv -----
// byte channel
interface utd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// code point channel
interface utd_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        is_replacement;
    logic        last_of_run;

    modport source (output valid, output code_point, output is_replacement,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input is_replacement,
                    input last_of_run, output ready);
endinterface

// ----- hw/rtl/utf8_to_code_point_decoder_unit.sv -----
// UTF-8 decoder: takes one byte word per cycle (or an end-of-stream word) and
// emits Unicode code points, with U+FFFD flagged by is_replacement for any
// malformed input. The byte is decoded in the same cycle it is taken, against
// the registered parse state, and its results (none, one or two) go into a
// three-entry result queue. With the sink always ready the unit sustains one
// byte per cycle; a byte that breaks an open sequence and also decodes on its
// own gives two results, and the queue absorbs the extra one until it holds
// more than one result not being taken, at which point bytes stall.
// last_of_run marks the final result of each input word.
module utf8_to_code_point_decoder_unit
    import utd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    utd_byte_if.sink   bytes,
    utd_cp_if.source   code_points
);

    localparam int unsigned QDepth = 3;

    parse_state_t state_reg, state_next;
    logic [14:0]  partial_reg, partial_next;

    result_t      queue_reg  [QDepth];
    result_t      queue_next [QDepth];
    result_t      queue_shft [QDepth];
    logic [1:0]   count_reg, count_next, count_after;

    result_t      res_a, res_b;
    logic [1:0]   n_res;
    decode_t      fs;
    logic         accept, pop;
    logic [7:0]   b;
    logic         is_cont;

    // decode one byte from the start state
    function automatic decode_t from_start(input logic [7:0] v);
        decode_t d;
        d.emit           = 1'b0;
        d.code_point     = ReplChar;
        d.is_replacement = 1'b1;
        d.state          = ST_START;
        d.partial        = '0;
        if (v inside {[8'h00:8'h7F]}) begin
            d.emit           = 1'b1;
            d.code_point     = {13'd0, v};
            d.is_replacement = 1'b0;
        end else if (v inside {[8'h80:8'hBF]}) begin
            d.emit = 1'b1;
        end else if (v inside {[8'hC0:8'hC1]}) begin
            d.state = ST_ERR1;
        end else if (v inside {[8'hC2:8'hDF]}) begin
            d.state   = ST_NEED1;
            d.partial = {10'd0, v[4:0]};
        end else if (v == 8'hE0) begin
            d.state   = ST_LEAD_E0;
            d.partial = {11'd0, v[3:0]};
        end else if (v == 8'hED) begin
            d.state   = ST_LEAD_ED;
            d.partial = {11'd0, v[3:0]};
        end else if (v inside {[8'hE1:8'hEF]}) begin
            d.state   = ST_NEED2;
            d.partial = {11'd0, v[3:0]};
        end else if (v == 8'hF0) begin
            d.state   = ST_LEAD_F0;
            d.partial = {12'd0, v[2:0]};
        end else if (v inside {[8'hF1:8'hF3]}) begin
            d.state   = ST_NEED3;
            d.partial = {12'd0, v[2:0]};
        end else if (v == 8'hF4) begin
            d.state   = ST_LEAD_F4;
            d.partial = {12'd0, v[2:0]};
        end else if (v inside {[8'hF5:8'hF7]}) begin
            d.state = ST_ERR3;
        end else if (v inside {[8'hF8:8'hFB]}) begin
            d.state = ST_ERR4;
        end else if (v inside {[8'hFC:8'hFD]}) begin
            d.state = ST_ERR5;
        end else begin
            d.emit = 1'b1;
        end
        return d;
    endfunction

    assign b       = bytes.in_byte;
    assign is_cont = (b inside {[8'h80:8'hBF]});
    assign fs      = from_start(b);

    // handshakes and queue room
    assign pop         = code_points.valid & code_points.ready;
    assign count_after = count_reg - {1'b0, pop};
    assign bytes.ready = (count_after <= 2'd1);
    assign accept      = bytes.valid & bytes.ready;

    // byte decode against current parse state
    always_comb
    begin
        result_t fail_res;
        result_t fs_res;
        fail_res     = '{code_point: ReplChar, is_replacement: 1'b1, last_of_run: 1'b0};
        fs_res       = '{code_point: fs.code_point, is_replacement: fs.is_replacement,
                         last_of_run: 1'b0};
        res_a        = fail_res;
        res_b        = fs_res;
        n_res        = 2'd0;
        state_next   = state_reg;
        partial_next = partial_reg;

        if (bytes.end_of_stream) begin
            if (state_reg != ST_START) begin
                n_res = 2'd1;
            end
            state_next = ST_START;
        end else if (state_reg == ST_START) begin
            res_a        = fs_res;
            n_res        = {1'b0, fs.emit};
            state_next   = fs.state;
            partial_next = fs.partial;
        end else if (!is_cont) begin
            // sequence broken: replacement, then the byte starts over
            n_res        = fs.emit ? 2'd2 : 2'd1;
            state_next   = fs.state;
            partial_next = fs.partial;
        end else begin
            case (state_reg)
                ST_ERR1:
                begin
                    n_res      = 2'd1;
                    state_next = ST_START;
                end
                ST_ERR2:    state_next = ST_ERR1;
                ST_ERR3:    state_next = ST_ERR2;
                ST_ERR4:    state_next = ST_ERR3;
                ST_ERR5:    state_next = ST_ERR4;
                ST_NEED1:
                begin
                    res_a      = '{code_point: {partial_reg, b[5:0]},
                                   is_replacement: 1'b0, last_of_run: 1'b0};
                    n_res      = 2'd1;
                    state_next = ST_START;
                end
                ST_NEED2:
                begin
                    partial_next = {partial_reg[8:0], b[5:0]};
                    state_next   = ST_NEED1;
                end
                ST_NEED3:
                begin
                    partial_next = {partial_reg[8:0], b[5:0]};
                    state_next   = ST_NEED2;
                end
                ST_LEAD_E0:
                begin
                    if (b <= 8'h9F) begin
                        state_next = ST_ERR1;
                    end else begin
                        partial_next = {partial_reg[8:0], b[5:0]};
                        state_next   = ST_NEED1;
                    end
                end
                ST_LEAD_ED:
                begin
                    if (b > 8'h9F) begin
                        state_next = ST_ERR1;
                    end else begin
                        partial_next = {partial_reg[8:0], b[5:0]};
                        state_next   = ST_NEED1;
                    end
                end
                ST_LEAD_F0:
                begin
                    if (b <= 8'h8F) begin
                        state_next = ST_ERR2;
                    end else begin
                        partial_next = {partial_reg[8:0], b[5:0]};
                        state_next   = ST_NEED2;
                    end
                end
                ST_LEAD_F4:
                begin
                    if (b > 8'h8F) begin
                        state_next = ST_ERR2;
                    end else begin
                        partial_next = {partial_reg[8:0], b[5:0]};
                        state_next   = ST_NEED2;
                    end
                end
                default:
                begin
                    res_a        = fs_res;
                    n_res        = {1'b0, fs.emit};
                    state_next   = fs.state;
                    partial_next = fs.partial;
                end
            endcase
        end

        res_a.last_of_run = (n_res == 2'd1);
        res_b.last_of_run = 1'b1;
    end

    // result queue: shift out at the head, append at the tail
    always_comb
    begin
        for (int i = 0; i < QDepth; i++) begin
            if (pop && (i < QDepth - 1)) begin
                queue_shft[i] = queue_reg[(i + 1) % QDepth];
            end else begin
                queue_shft[i] = queue_reg[i];
            end
        end
        for (int i = 0; i < QDepth; i++) begin
            queue_next[i] = queue_shft[i];
            if (accept && (n_res != 2'd0) && (count_after == 2'(i))) begin
                queue_next[i] = res_a;
            end
            if (accept && (n_res == 2'd2) && ((count_after + 2'd1) == 2'(i))) begin
                queue_next[i] = res_b;
            end
        end
        count_next = count_after + (accept ? n_res : 2'd0);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_START;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept) begin
            partial_reg <= partial_next;
        end
        for (int i = 0; i < QDepth; i++) begin
            queue_reg[i] <= queue_next[i];
        end
    end

    // output word from queue head
    assign code_points.valid          = (count_reg != 2'd0);
    assign code_points.code_point     = queue_reg[0].code_point;
    assign code_points.is_replacement = queue_reg[0].is_replacement;
    assign code_points.last_of_run    = queue_reg[0].last_of_run;

endmodule
